/* hdl/chol_pkg.sv */
package chol_pkg;
   localparam int MaxN = 8;
   localparam int FracBits = 16;
   localparam logic [3:0] SizeReset = 4'd8;
endpackage

/* hdl/chol_ram.sv */
module chol_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/chol_alu.sv */
module chol_alu
   import chol_pkg::*;
#(
   parameter int FRAC_BITS = FracBits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_start,
   input  logic               op_is_sqrt,
   input  logic signed [63:0] op_num,
   input  logic        [31:0] op_piv,
   output logic               op_done,
   output logic signed [31:0] op_result
);
   localparam int IterCount = 48;

   logic              busy_ff, busy_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              sqrt_ff, sqrt_in, neg_ff, neg_in;
   logic              sat_ff, sat_in;
   logic [95:0]       rem_ff, rem_in;
   logic [63:0]       quo_ff, quo_in;
   logic [31:0]       piv_ff, piv_in;
   logic [95:0]       val_ff, val_in;
   logic              done_ff, done_in;
   logic signed [31:0] res_ff, res_in;
   logic [63:0]       mag;
   logic [95:0]       trial;
   logic [95:0]       rem_sh;
   logic [63:0]       sat_q;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sqrt_in = sqrt_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      piv_in  = piv_ff;
      val_in  = val_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      mag     = op_num[63] ? 64'(-op_num) : 64'(op_num);
      rem_sh  = '0;
      trial   = '0;
      sat_q   = '0;
      if (op_start) begin
         busy_in = 1'b1;
         sqrt_in = op_is_sqrt;
         neg_in  = op_num[63];
         piv_in  = op_piv;
         rem_in  = '0;
         quo_in  = '0;
         sat_in  = (mag >> (62 - FRAC_BITS)) != 64'd0;
         if (op_is_sqrt) begin
            val_in = 96'(mag) << FRAC_BITS;
            cnt_in = 7'(IterCount);
         end else begin
            val_in = 96'(mag) << (FRAC_BITS + 32);
            cnt_in = 7'(IterCount + 16);
         end
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            rem_sh = {rem_ff[93:0], val_ff[95:94]};
            val_in = {val_ff[93:0], 2'b00};
            trial  = {30'd0, quo_ff, 2'b01};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end else begin
            rem_sh = {rem_ff[94:0], val_ff[95]};
            val_in = {val_ff[94:0], 1'b0};
            trial  = 96'(piv_ff);
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (busy_ff && !sqrt_ff && cnt_ff == 7'd1) begin
         sat_q = sat_ff ? 64'h1_0000_0000 : quo_in;
         if (neg_ff) begin
            res_in = (sat_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-sat_q);
         end else begin
            res_in = (sat_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(sat_q);
         end
      end else if (busy_ff && sqrt_ff && cnt_ff == 7'd1) begin
         res_in = 32'(quo_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sqrt_ff <= sqrt_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      piv_ff  <= piv_in;
      val_ff  <= val_in;
      res_ff  <= res_in;
   end

   assign op_done   = done_ff;
   assign op_result = res_ff;
endmodule

/* hdl/cholesky_factorization.sv */
// loading: one request per cycle while start high and csr_wr_en low, n*n requests per matrix, busy low
// factoring: each element reads A, then L(i,k) and L(j,k) per multiply, then L(j,j) for the ALU;
// once a pivot fails each later element is written as zero; busy high until the last result
// output: each result is read from the RAM and registered, n*n results back to back, no stall possible
// a new matrix is loaded only after the last result of the previous one
// synchronous reset returns to loading, clears the load count, the error flag and valid, sets size to 8
module cholesky_factorization
   import chol_pkg::*;
#(
   parameter int MAX_N = MaxN,
   parameter int FRAC_BITS = FracBits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_a_value,
   input  logic               csr_wr_en,
   input  logic        [3:0]  csr_wr_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_l_value,
   output logic               rsp_is_last,
   output logic               rsp_status
);
   localparam int IdxW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int AddrW = 2 * IdxW;
   localparam int Depth = 1 << AddrW;

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_RDA   = 8'b0000_0010,
      ST_RDX   = 8'b0000_0100,
      ST_RDY   = 8'b0000_1000,
      ST_MAC   = 8'b0001_0000,
      ST_RDP   = 8'b0010_0000,
      ST_ALU   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         size_ff, size_in;
   logic [IdxW:0]      lr_ff, lr_in, lc_ff, lc_in;
   logic [IdxW:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic               err_ff, err_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [63:0] num_ff, num_in;
   logic [1:0]         ph_ff, ph_in;
   logic               vld_ff, vld_in, last_ff, last_in;
   logic signed [31:0] oval_ff, oval_in;
   logic [IdxW:0]      n;
   logic               wr_en;
   logic [AddrW-1:0]   wr_addr, rd_addr;
   logic [31:0]        wr_data, rd_data;
   logic               alu_start, alu_sqrt, alu_done;
   logic signed [31:0] alu_res;
   logic signed [63:0] prod;
   logic signed [63:0] prod_rnd;

   function automatic logic [AddrW-1:0] addr_of(input logic [IdxW:0] r, input logic [IdxW:0] c);
      addr_of = {r[IdxW-1:0], c[IdxW-1:0]};
   endfunction

   always_comb begin
      if (size_ff == 4'd0) begin
         n = (IdxW+1)'(1);
      end else if (32'(size_ff) > MAX_N) begin
         n = (IdxW+1)'(MAX_N);
      end else begin
         n = (IdxW+1)'(size_ff);
      end
   end

   chol_ram #(.Width(32), .Depth(Depth)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   chol_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock(clock), .reset(reset), .op_start(alu_start), .op_is_sqrt(alu_sqrt),
      .op_num(num_ff), .op_piv(rd_data), .op_done(alu_done), .op_result(alu_res)
   );

   assign prod     = 64'(x_ff) * 64'($signed(rd_data));
   assign prod_rnd = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

   always_comb begin
      state_in  = state_ff;
      size_in   = size_ff;
      lr_in     = lr_ff;
      lc_in     = lc_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      num_in    = num_ff;
      ph_in     = ph_ff;
      vld_in    = 1'b0;
      last_in   = 1'b0;
      oval_in   = oval_ff;
      wr_en     = 1'b0;
      wr_addr   = addr_of(lr_ff, lc_ff);
      wr_data   = req_a_value;
      rd_addr   = addr_of(i_ff, j_ff);
      alu_start = 1'b0;
      alu_sqrt  = (i_ff == j_ff);
      case (state_ff)
         ST_LOAD: begin
            if (csr_wr_en) begin
               size_in = csr_wr_data;
               lr_in   = '0;
               lc_in   = '0;
            end else if (start) begin
               wr_en = 1'b1;
               if (lc_ff == n - 1'b1) begin
                  lc_in = '0;
                  if (lr_ff == n - 1'b1) begin
                     lr_in    = '0;
                     i_in     = '0;
                     j_in     = '0;
                     err_in   = 1'b0;
                     state_in = ST_RDA;
                  end else begin
                     lr_in = lr_ff + 1'b1;
                  end
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
            end
         end
         ST_RDA: begin
            rd_addr = addr_of(i_ff, j_ff);
            acc_in  = '0;
            k_in    = '0;
            ph_in   = 2'd0;
            if (err_ff) begin
               wr_en    = 1'b1;
               wr_addr  = addr_of(i_ff, j_ff);
               wr_data  = '0;
               state_in = ST_ALU;
               ph_in    = 2'd3;
            end else begin
               state_in = (j_ff == '0) ? ST_MAC : ST_RDX;
               ph_in    = (j_ff == '0) ? 2'd1 : 2'd0;
            end
         end
         ST_RDX: begin
            if (ph_ff == 2'd0) begin
               num_in = 64'($signed(rd_data));
            end
            rd_addr  = addr_of(i_ff, k_ff);
            state_in = ST_RDY;
         end
         ST_RDY: begin
            x_in     = rd_data;
            rd_addr  = addr_of(j_ff, k_ff);
            state_in = ST_MAC;
            ph_in    = 2'd2;
         end
         ST_MAC: begin
            if (ph_ff == 2'd1) begin
               num_in = 64'($signed(rd_data));
            end else begin
               acc_in = acc_ff + prod_rnd;
               k_in   = k_ff + 1'b1;
            end
            if (ph_ff != 2'd1 && k_ff + 1'b1 < j_ff) begin
               rd_addr  = addr_of(i_ff, k_ff + 1'b1);
               ph_in    = 2'd2;
               state_in = ST_RDY;
            end else begin
               rd_addr  = addr_of(j_ff, j_ff);
               state_in = ST_RDP;
            end
         end
         ST_RDP: begin
            rd_addr  = addr_of(j_ff, j_ff);
            num_in   = num_ff - acc_ff;
            state_in = ST_ALU;
            ph_in    = 2'd0;
         end
         ST_ALU: begin
            rd_addr = addr_of(j_ff, j_ff);
            if (ph_ff == 2'd0) begin
               if (num_ff <= 0 && i_ff == j_ff) begin
                  err_in  = 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = addr_of(i_ff, j_ff);
                  wr_data = '0;
                  ph_in   = 2'd3;
               end else begin
                  alu_start = 1'b1;
                  ph_in     = 2'd1;
               end
            end else if (ph_ff == 2'd1) begin
               if (alu_done) begin
                  wr_en   = 1'b1;
                  wr_addr = addr_of(i_ff, j_ff);
                  wr_data = alu_res;
                  ph_in   = 2'd3;
               end
            end else begin
               if (j_ff == i_ff) begin
                  j_in = '0;
                  if (i_ff == n - 1'b1) begin
                     i_in     = '0;
                     state_in = ST_OUT;
                     ph_in    = 2'd0;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = ST_RDA;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_RDA;
               end
            end
         end
         ST_OUT: begin
            rd_addr = addr_of(i_ff, j_ff);
            if (ph_ff == 2'd1) begin
               vld_in  = 1'b1;
               oval_in = (lc_ff <= lr_ff) ? rd_data : '0;
               last_in = (lr_ff == n - 1'b1) && (lc_ff == n - 1'b1);
               if (last_in) begin
                  lr_in    = '0;
                  lc_in    = '0;
                  state_in = ST_LOAD;
               end else if (lc_ff == n - 1'b1) begin
                  lc_in = '0;
                  lr_in = lr_ff + 1'b1;
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
            end
            ph_in = 2'd1;
            if (j_ff == n - 1'b1) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         size_ff  <= SizeReset;
         lr_ff    <= '0;
         lc_ff    <= '0;
         err_ff   <= 1'b0;
         vld_ff   <= 1'b0;
         ph_ff    <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         lr_ff    <= lr_in;
         lc_ff    <= lc_in;
         err_ff   <= err_in;
         vld_ff   <= vld_in;
         ph_ff    <= ph_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      num_ff  <= num_in;
      last_ff <= last_in;
      oval_ff <= oval_in;
   end

   assign busy        = (state_ff != ST_LOAD);
   assign rsp_valid   = vld_ff;
   assign rsp_l_value = oval_ff;
   assign rsp_is_last = last_ff;
   assign rsp_status  = err_ff;

   a_no_accept_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !wr_en || state_ff == ST_RDA || state_ff == ST_ALU)
      else $error("load write outside load state");
   a_last_ends_out: assert property (@(posedge clock) disable iff (reset)
      (vld_in && last_in) |=> (state_ff == ST_LOAD))
      else $error("last result did not return to load");
   a_valid_only_out: assert property (@(posedge clock) disable iff (reset)
      vld_in |-> (state_ff == ST_OUT))
      else $error("result outside output phase");
endmodule

/* tb/tb_cholesky_factorization.sv */
`timescale 1ns / 1ps

module tb_cholesky_factorization
   import chol_pkg::*;
();

   localparam int CycleLimit = 3_000_000;

   typedef struct packed {
      logic signed [31:0] l_value;
      logic               is_last;
      logic               status;
   } factor_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_a_value = '0;
   logic               csr_wr_en = 1'b0;
   logic        [3:0]  csr_wr_data = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_l_value;
   logic               rsp_is_last;
   logic               rsp_status;

   factor_entry_type   factor_q[$];
   logic signed [31:0] model_store[MaxN*MaxN];
   logic        [3:0]  model_size;
   int unsigned        model_load;
   int unsigned        errors = 0;
   int unsigned        requests = 0;
   int unsigned        matrices = 0;
   int unsigned        bad_matrices = 0;
   int unsigned        results = 0;
   int unsigned        cycles = 0;
   bit                 no_gaps = 1'b0;

   always #4 clock = ~clock;

   cholesky_factorization i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_a_value(req_a_value),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_l_value(rsp_l_value),
      .rsp_is_last(rsp_is_last),
      .rsp_status (rsp_status)
   );

   function automatic int unsigned matrix_order();
      if (model_size < 1) return 1;
      if (model_size > MaxN) return MaxN;
      return model_size;
   endfunction

   function automatic longint stored(int unsigned r, int unsigned c);
      return longint'(model_store[r*MaxN + c]);
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // factors the loaded matrix in place and queues the n*n factor entries
   task automatic factor_matrix(int unsigned n);
      bit               err;
      longint           res, a, s, p, d, num, piv;
      bit [63:0]        mag, q;
      factor_entry_type e;
      err = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
         for (int unsigned j = 0; j <= i; j++) begin
            res = 0;
            if (!err) begin
               a = stored(i, j);
               s = 0;
               for (int unsigned k = 0; k < j; k++) begin
                  p = stored(i, k) * stored(j, k);
                  s += (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
               end
               if (i == j) begin
                  d = a - s;
                  if (d <= 0) err = 1'b1;
                  else res = longint'(int_sqrt(64'(d) << FracBits));
               end else begin
                  num = a - s;
                  piv = stored(j, j);
                  mag = num < 0 ? 64'(-num) : 64'(num);
                  if (piv < 1) begin
                     err = 1'b1;
                  end else begin
                     if (mag >= (64'd1 << (62 - FracBits))) q = 64'd1 << 32;
                     else q = (mag << FracBits) / unsigned'(piv);
                     if (num < 0) res = q > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(q);
                     else res = q > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(q);
                  end
               end
            end
            model_store[i*MaxN + j] = res[31:0];
         end
      end
      for (int unsigned r = 0; r < n; r++) begin
         for (int unsigned c = 0; c < n; c++) begin
            e.l_value = c <= r ? model_store[r*MaxN + c] : '0;
            e.is_last = (r == n - 1) && (c == n - 1);
            e.status  = err;
            factor_q.insert(factor_q.size(), e);
         end
      end
      matrices++;
      if (err) bad_matrices++;
   endtask

   task automatic load_entry(logic signed [31:0] v);
      int unsigned n;
      n = matrix_order();
      if (model_load >= n*n) model_load = 0;
      model_store[(model_load / n)*MaxN + model_load % n] = v;
      model_load++;
      if (model_load == n*n) begin
         model_load = 0;
         factor_matrix(n);
      end
   endtask

   task automatic send_request(logic signed [31:0] v);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_a_value <= v;
      do @(posedge clock); while (busy);
      load_entry(v);
      requests++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (factor_q.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(logic [3:0] v);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      model_size = v;
      model_load = 0;
   endtask

   task automatic send_matrix(bit well_formed);
      int unsigned n;
      n = matrix_order();
      for (int unsigned r = 0; r < n; r++) begin
         for (int unsigned c = 0; c < n; c++) begin
            if (!well_formed || c > r) send_request($urandom());
            else if (c < r) send_request($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            else send_request(n * (1 << 18) + $urandom_range(1, 1 << 24));
         end
      end
   endtask

   task automatic test_single_entry();
      write_size(4'd1);
      send_request(32'sh7FFF_FFFF);
      send_request(32'sh8000_0000);
      send_request(32'sd0);
      send_request(32'sd1);
      write_size(4'd0);
      send_request(32'sh0001_0000);
   endtask

   task automatic test_partial_load();
      write_size(4'd3);
      repeat (4) send_request($urandom());
      write_size(4'd2);
      send_request(32'sh0004_0000);
      send_request(32'sh1234_5678);
      send_request(-32'sh0002_0000);
      send_request(32'sh0005_0000);
   endtask

   task automatic test_saturation();
      write_size(4'd2);
      send_request(32'sd1);
      send_request(32'sd0);
      send_request(32'sh7FFF_FFFF);
      send_request(32'sh7FFF_FFFF);
      send_request(32'sd1);
      send_request(32'sd0);
      send_request(32'sh8000_0000);
      send_request(32'sd1);
   endtask

   task automatic test_random_matrices();
      int unsigned pick;
      logic [3:0]  sz;
      while (requests < 330) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) sz = 4'd0;
         else if (pick == 1) sz = 4'($urandom_range(8, 15));
         else if (pick < 5) sz = 4'($urandom_range(5, 7));
         else sz = 4'($urandom_range(1, 4));
         write_size(sz);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) send_matrix($urandom_range(0, 6) != 0);
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_request($urandom());
         no_gaps = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("%0t timeout after %0d cycles", $time, cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      factor_entry_type e;
      if (!reset && rsp_valid) begin
         results++;
         if (factor_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result l_value=%h", $time, rsp_l_value);
         end else begin
            e = factor_q.pop_front();
            if (rsp_l_value !== e.l_value) begin
               errors++;
               $display("%0t l_value expected %h actual %h", $time, e.l_value, rsp_l_value);
            end
            if (rsp_is_last !== e.is_last) begin
               errors++;
               $display("%0t is_last expected %b actual %b", $time, e.is_last, rsp_is_last);
            end
            if (rsp_status !== e.status) begin
               errors++;
               $display("%0t status expected %b actual %b", $time, e.status, rsp_status);
            end
         end
      end
   end

   initial begin
      foreach (model_store[i]) model_store[i] = '0;
      model_size = SizeReset;
      model_load = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_entry();
      test_partial_load();
      test_saturation();
      test_random_matrices();
      wait_idle();
      if (factor_q.size() != 0) begin
         errors++;
         $display("%0t %0d results never arrived", $time, factor_q.size());
      end
      $display("%0d requests, %0d matrices factored (%0d not positive definite)",
               requests, matrices, bad_matrices);
      $display("%0d factor entries checked, %0d mismatches", results, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
